[design/oahi_pkg.sv]
// ----------------------------------------------------------------------------
// oahi_pkg
// Shared widths, operation and status codes, and types for the hash insert block.
// ----------------------------------------------------------------------------
package oahi_pkg;

  localparam int KEY_W    = 16;
  localparam int OP_W     = 2;
  localparam int IDX_W    = 4;
  localparam int STATUS_W = 3;
  localparam int PCNT_W   = 4;
  localparam int MODE_W   = 2;
  localparam int NIB_W    = 4;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_STORED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DUP     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_CLEARED = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_READ    = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_ZERO    = 3'd5;

  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    slot;
    logic [KEY_W-1:0]    slot_key;
    logic [PCNT_W-1:0]   probe_count;
  } result_t;

  typedef struct packed {
    logic load;
    logic advance;
  } probe_ctrl_t;

endpackage

[design/oahi_ifs.sv]
// ----------------------------------------------------------------------------
// oahi_ifs
// Valid/ready channels for operation beats in and result beats out.
// ----------------------------------------------------------------------------
interface oahi_in_if;
  logic                        valid;
  logic                        ready;
  logic [oahi_pkg::OP_W-1:0]   operation;
  logic [oahi_pkg::KEY_W-1:0]  key;
  logic [oahi_pkg::IDX_W-1:0]  slot_index;

  modport source (output valid, operation, key, slot_index, input ready);
  modport sink   (input valid, operation, key, slot_index, output ready);
endinterface

interface oahi_out_if;
  logic                           valid;
  logic                           ready;
  logic [oahi_pkg::STATUS_W-1:0]  status;
  logic [oahi_pkg::IDX_W-1:0]     slot;
  logic [oahi_pkg::KEY_W-1:0]     slot_key;
  logic [oahi_pkg::PCNT_W-1:0]    probe_count;

  modport source (output valid, status, slot, slot_key, probe_count, input ready);
  modport sink   (input valid, status, slot, slot_key, probe_count, output ready);
endinterface

[design/oahi_mod_unit.sv]
// ----------------------------------------------------------------------------
// oahi_mod_unit
// Key modulo a constant divisor, one nibble per cycle with compare-subtracts.
// ----------------------------------------------------------------------------
module oahi_mod_unit #(
  parameter int DIVISOR = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start_i,
  input  logic [oahi_pkg::KEY_W-1:0]    value_i,
  output logic                          done_o,
  output logic [$clog2(DIVISOR)-1:0]    rem_o
);

  localparam int REM_W = $clog2(DIVISOR);
  localparam int RW    = REM_W + oahi_pkg::NIB_W;
  localparam int STEPS = oahi_pkg::KEY_W / oahi_pkg::NIB_W;
  localparam int SCW   = $clog2(STEPS);

  logic [oahi_pkg::KEY_W-1:0] sh_r;
  logic [REM_W-1:0]           rem_r;
  logic [SCW-1:0]             cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [RW-1:0]              t_v;

  // remainder * 16 + nibble stays below 16 * DIVISOR, four subtracts bring it under
  always_comb begin
    t_v = {rem_r, sh_r[oahi_pkg::KEY_W-1 -: oahi_pkg::NIB_W]};
    for (int k = oahi_pkg::NIB_W - 1; k >= 0; k--) begin
      if (t_v >= (RW'(DIVISOR) << k)) begin
        t_v = t_v - (RW'(DIVISOR) << k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        sh_r   <= value_i;
      end else if (busy_r) begin
        rem_r <= t_v[REM_W-1:0];
        sh_r  <= sh_r << oahi_pkg::NIB_W;
        cnt_r <= cnt_r + SCW'(1);
        if (cnt_r == SCW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_r;
  assign rem_o  = rem_r;

endmodule

[design/oahi_probe_unit.sv]
// ----------------------------------------------------------------------------
// oahi_probe_unit
// Probe address stepper: one modular adder steps the current slot, a second the quadratic increment.
// ----------------------------------------------------------------------------
module oahi_probe_unit #(
  parameter int SLOTS = 11
) (
  input  logic                          clk,
  input  oahi_pkg::probe_ctrl_t         ctrl_i,
  input  logic [oahi_pkg::MODE_W-1:0]   mode_i,
  input  logic [$clog2(SLOTS)-1:0]      home_i,
  input  logic [$clog2(SLOTS)-1:0]      step_i,
  output logic [$clog2(SLOTS)-1:0]      cur_o,
  output logic                          last_o
);

  localparam int IW = $clog2(SLOTS);

  logic [IW-1:0] cur_r;
  logic [IW-1:0] home_r;
  logic [IW-1:0] inc_r;
  logic [IW-1:0] step_r;
  logic [IW-1:0] delta;
  logic [IW-1:0] cur_nxt;
  logic [IW-1:0] inc_nxt;

  function automatic logic [IW-1:0] mod_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IW+1)'(SLOTS)) begin
      s = s - (IW+1)'(SLOTS);
    end
    return s[IW-1:0];
  endfunction

  always_comb begin
    case (mode_i)
      oahi_pkg::MODE_QUAD:   delta = inc_r;
      oahi_pkg::MODE_DOUBLE: delta = step_r;
      default:               delta = IW'(1);
    endcase
    cur_nxt = mod_add(cur_r, delta);
    // quadratic offsets grow by 2a+1 each attempt
    inc_nxt = mod_add(inc_r, IW'(2));
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.load) begin
      cur_r  <= home_i;
      home_r <= home_i;
      inc_r  <= IW'(1);
      step_r <= step_i;
    end else if (ctrl_i.advance) begin
      cur_r <= cur_nxt;
      inc_r <= inc_nxt;
    end
  end

  assign cur_o  = cur_r;
  assign last_o = (cur_nxt == home_r);

endmodule

[design/oahi_table.sv]
// ----------------------------------------------------------------------------
// oahi_table
// Key store: one write and one registered read per cycle, valid bit per slot.
// ----------------------------------------------------------------------------
module oahi_table #(
  parameter int SLOTS = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clr_i,
  input  logic [$clog2(SLOTS)-1:0]      rd_addr_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(SLOTS)-1:0]      wr_addr_i,
  input  logic [oahi_pkg::KEY_W-1:0]    wr_key_i,
  output logic [oahi_pkg::KEY_W-1:0]    rd_key_o
);

  logic [oahi_pkg::KEY_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0]           vld_r;
  logic [oahi_pkg::KEY_W-1:0] rd_key_r;
  logic                       rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_key_i;
    end
    rd_key_r <= mem[rd_addr_i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr_i];
      if (clr_i) begin
        vld_r <= '0;
      end else if (wr_en_i) begin
        vld_r[wr_addr_i] <= 1'b1;
      end
    end
  end

  // a slot never written since the last clear reads as empty
  assign rd_key_o = rd_vld_r ? rd_key_r : '0;

endmodule

[design/open_addressing_hash_insert.sv]
// ----------------------------------------------------------------------------
// open_addressing_hash_insert
// Open-addressing key table with linear, quadratic or double-hash probing.
// ----------------------------------------------------------------------------
//   channel   dir   handshake       payload
//   in_chan   in    valid / ready   operation, key, slot_index
//   out_chan  out   valid / ready   status, slot, slot_key, probe_count
//   cfg_*     in    wr_en           probe_mode
//
// An insert first reduces its key in the nibble modulo units, then examines
// one slot per cycle through the table's single read port.
// Reset clears all slot valid bits at once; no clearing pass is needed.
// in_chan is ready only when idle; a finished result waits in the output
// register while out_chan is stalled.
module open_addressing_hash_insert #(
  parameter int TABLE_SLOTS = 11,
  parameter int STEP_PRIME  = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [oahi_pkg::MODE_W-1:0]   cfg_wr_data,
  oahi_in_if.sink                       in_chan,
  oahi_out_if.source                    out_chan
);

  localparam int IW  = $clog2(TABLE_SLOTS);
  localparam int SPW = $clog2(STEP_PRIME);
  localparam int CW  = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_HASH, S_PROBE, S_READ, S_DONE} state_t;

  state_t                         state_r, state_nxt;
  logic [oahi_pkg::MODE_W-1:0]    mode_r;
  logic [oahi_pkg::KEY_W-1:0]     key_r, key_nxt;
  logic [oahi_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic                           idx_ok_r, idx_ok_nxt;
  logic                           cmp_v_r, cmp_v_nxt;
  logic [IW-1:0]                  cmp_addr_r, cmp_addr_nxt;
  logic                           cmp_last_r, cmp_last_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  oahi_pkg::result_t              res_r, res_nxt;
  oahi_pkg::result_t              out_r, out_nxt;
  logic                           out_valid_r, out_valid_nxt;

  logic                           in_beat;
  logic                           idx_ok;
  logic                           mod_start;
  logic                           home_done;
  logic                           step_done;
  logic [IW-1:0]                  home;
  logic [SPW-1:0]                 key_mod_sp;
  logic [IW-1:0]                  step_tab [STEP_PRIME];
  oahi_pkg::probe_ctrl_t          pctl;
  logic [IW-1:0]                  cur;
  logic                           last;
  logic                           tbl_clr;
  logic [IW-1:0]                  rd_addr;
  logic                           wr_en;
  logic [oahi_pkg::KEY_W-1:0]     rd_key;
  logic [CW-1:0]                  cnt_inc;

  function automatic logic [oahi_pkg::PCNT_W-1:0] sat_count(input logic [CW-1:0] c);
    if (32'(c) > 32'd15) begin
      return oahi_pkg::PCNT_W'(15);
    end
    return oahi_pkg::PCNT_W'(c);
  endfunction

  // double-hash step (prime - key mod prime), already reduced mod table size
  for (genvar g = 0; g < STEP_PRIME; g++) begin : g_step
    assign step_tab[g] = IW'((STEP_PRIME - g) % TABLE_SLOTS);
  end

  oahi_mod_unit #(.DIVISOR(TABLE_SLOTS)) u_mod_home (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mod_start),
    .value_i (in_chan.key),
    .done_o  (home_done),
    .rem_o   (home)
  );

  oahi_mod_unit #(.DIVISOR(STEP_PRIME)) u_mod_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mod_start),
    .value_i (in_chan.key),
    .done_o  (step_done),
    .rem_o   (key_mod_sp)
  );

  oahi_probe_unit #(.SLOTS(TABLE_SLOTS)) u_probe (
    .clk    (clk),
    .ctrl_i (pctl),
    .mode_i (mode_r),
    .home_i (home),
    .step_i (step_tab[key_mod_sp]),
    .cur_o  (cur),
    .last_o (last)
  );

  oahi_table #(.SLOTS(TABLE_SLOTS)) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr_i     (tbl_clr),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (cmp_addr_r),
    .wr_key_i  (key_r),
    .rd_key_o  (rd_key)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_beat       = in_chan.valid && (state_r == S_IDLE);
  assign idx_ok        = (32'(in_chan.slot_index) < TABLE_SLOTS);
  assign cnt_inc       = cnt_r + CW'(1);

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    idx_ok_nxt    = idx_ok_r;
    cmp_v_nxt     = cmp_v_r;
    cmp_addr_nxt  = cmp_addr_r;
    cmp_last_nxt  = cmp_last_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    mod_start     = 1'b0;
    pctl          = '0;
    tbl_clr       = 1'b0;
    wr_en         = 1'b0;
    rd_addr       = '0;

    case (state_r)
      S_IDLE: begin
        rd_addr = idx_ok ? IW'(in_chan.slot_index) : '0;
        if (in_beat) begin
          res_nxt = '0;
          case (in_chan.operation)
            oahi_pkg::OP_INSERT: begin
              if (in_chan.key == '0) begin
                res_nxt.status = oahi_pkg::STAT_ZERO;
                state_nxt      = S_DONE;
              end else begin
                key_nxt   = in_chan.key;
                mod_start = 1'b1;
                state_nxt = S_HASH;
              end
            end
            oahi_pkg::OP_CLEAR: begin
              tbl_clr        = 1'b1;
              res_nxt.status = oahi_pkg::STAT_CLEARED;
              state_nxt      = S_DONE;
            end
            oahi_pkg::OP_READ: begin
              idx_nxt    = in_chan.slot_index;
              idx_ok_nxt = idx_ok;
              state_nxt  = S_READ;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_HASH: begin
        if (home_done && step_done) begin
          pctl.load = 1'b1;
          cmp_v_nxt = 1'b0;
          cnt_nxt   = '0;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        // reads run one slot ahead of the compare; the extra read is dropped
        rd_addr      = cur;
        pctl.advance = 1'b1;
        cmp_v_nxt    = 1'b1;
        cmp_addr_nxt = cur;
        cmp_last_nxt = last;
        if (cmp_v_r) begin
          cnt_nxt             = cnt_inc;
          res_nxt.probe_count = sat_count(cnt_inc);
          if (rd_key == '0) begin
            wr_en          = 1'b1;
            res_nxt.status = oahi_pkg::STAT_STORED;
            res_nxt.slot   = oahi_pkg::IDX_W'(cmp_addr_r);
            state_nxt      = S_DONE;
          end else if (rd_key == key_r) begin
            res_nxt.status = oahi_pkg::STAT_DUP;
            res_nxt.slot   = oahi_pkg::IDX_W'(cmp_addr_r);
            state_nxt      = S_DONE;
          end else if (cmp_last_r) begin
            res_nxt.status = oahi_pkg::STAT_FULL;
            state_nxt      = S_DONE;
          end
        end
      end
      S_READ: begin
        res_nxt.status   = oahi_pkg::STAT_READ;
        res_nxt.slot     = idx_r;
        res_nxt.slot_key = idx_ok_r ? rd_key : '0;
        state_nxt        = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= oahi_pkg::MODE_LINEAR;
      out_valid_r <= 1'b0;
      cmp_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_v_r     <= cmp_v_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
    end
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
    idx_ok_r   <= idx_ok_nxt;
    cmp_addr_r <= cmp_addr_nxt;
    cmp_last_r <= cmp_last_nxt;
    cnt_r      <= cnt_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_r.status;
  assign out_chan.slot        = out_r.slot;
  assign out_chan.slot_key    = out_r.slot_key;
  assign out_chan.probe_count = out_r.probe_count;

endmodule
